// ===== rtl/sdspi_pkg.sv =====
package sdspi_pkg;

  // Request kinds carried on in_tuser.
  localparam logic [1:0] CMD_START_CMD  = 2'd0;
  localparam logic [1:0] CMD_START_SYNC = 2'd1;
  localparam logic [1:0] CMD_RX_BYTE    = 2'd2;

  // Result kinds carried on out_tuser.
  localparam logic [1:0] KIND_XMIT    = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_IGNORED = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_POLL_LIMIT = 1'b0;
  localparam logic CFG_SYNC_COUNT = 1'b1;

  localparam logic [7:0] IDLE_BYTE       = 8'hFF;
  localparam logic [7:0] CMD_START_BITS  = 8'h40;
  localparam logic [7:0] CRC_END_BIT     = 8'h01;
  localparam logic [7:0] POLL_LIMIT_RST  = 8'd9;
  localparam logic [7:0] SYNC_COUNT_RST  = 8'd74;
  localparam logic [7:0] FRAME_BYTES     = 8'd6;
  localparam logic [7:0] DATA_BYTES      = 8'd4;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic        resp_long;
    logic [7:0]  cmd_crc;
    logic [31:0] cmd_arg;
    logic [5:0]  cmd_index;
  } in_fields_t;

  typedef struct packed {
    logic [31:0] resp_data;
    logic [7:0]  r1_status;
    logic        cs_active;
    logic [7:0]  tx_byte;
  } out_fields_t;

endpackage

// ===== rtl/sd_spi_command_sequencer.sv =====
// SD card SPI-mode host sequencer working one SPI byte at a time. A start request on the
// input stream (in_tuser 0 = command, 1 = power-up sync) is answered with the first byte to
// send; every later request carries the byte received on MISO and is answered with the next
// MOSI byte and chip-select level, or with the finished reply (R1 and, for R3/R7, four data
// bytes). The next state and the result are formed in a single pass of logic and stored in
// the output register, so a request can be accepted on every clock unless the output stalls,
// also while the previous result is being taken. Requests that do not fit the current
// phase are answered with an ignored result and leave the state untouched. Configuration
// (poll limit, sync count) may be written only while no transaction is under way.
module sd_spi_command_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cmd_index[5:0], cmd_arg[37:6], cmd_crc[45:38], resp_long[46], rx_byte[54:47], zero[55]
  input  logic [55:0] in_tdata,
  // cmd[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tx_byte[7:0], cs_active[8], r1_status[16:9], resp_data[48:17], zero[55:49]
  output logic [55:0] out_tdata,
  // result_kind[1:0]
  output logic [1:0]  out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_P_PRE, PH_P_SYNC, PH_P_POST, PH_C_PRE, PH_C_SEL,
    PH_C_FRAME, PH_C_POLL, PH_C_DATA, PH_C_TAIL, PH_C_END
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [47:0] frame_r, frame_nxt;
  logic [7:0]  byte_count_r, byte_count_nxt;
  logic [7:0]  poll_count_r, poll_count_nxt;
  logic [7:0]  r1_hold_r, r1_hold_nxt;
  logic [31:0] data_hold_r, data_hold_nxt;
  logic        long_reply_r, long_reply_nxt;
  logic [7:0]  poll_limit_r, sync_count_r;

  logic                    out_valid_r;
  logic [1:0]              out_kind_r;
  sdspi_pkg::out_fields_t  out_fields_r;

  sdspi_pkg::in_fields_t   in_f;
  sdspi_pkg::out_fields_t  res;
  logic [1:0]              res_kind;
  logic [7:0]              limit;
  logic [7:0]              r1_sel;
  logic                    in_acc;

  assign in_f      = sdspi_pkg::in_fields_t'(in_tdata[54:0]);
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  // A poll limit of zero still makes one poll.
  assign limit     = (poll_limit_r == 8'd0) ? 8'd1 : poll_limit_r;

  always_comb begin
    phase_nxt      = phase_r;
    frame_nxt      = frame_r;
    byte_count_nxt = byte_count_r;
    poll_count_nxt = poll_count_r;
    r1_hold_nxt    = r1_hold_r;
    data_hold_nxt  = data_hold_r;
    long_reply_nxt = long_reply_r;
    res_kind       = sdspi_pkg::KIND_IGNORED;
    res            = '0;
    r1_sel         = (in_f.rx_byte != sdspi_pkg::IDLE_BYTE) ? in_f.rx_byte
                                                             : sdspi_pkg::IDLE_BYTE;

    if (in_tuser == sdspi_pkg::CMD_START_CMD || in_tuser == sdspi_pkg::CMD_START_SYNC) begin
      if (phase_r == PH_IDLE) begin
        r1_hold_nxt    = sdspi_pkg::IDLE_BYTE;
        data_hold_nxt  = '0;
        byte_count_nxt = '0;
        poll_count_nxt = '0;
        res_kind       = sdspi_pkg::KIND_XMIT;
        res.tx_byte    = sdspi_pkg::IDLE_BYTE;
        if (in_tuser == sdspi_pkg::CMD_START_CMD) begin
          frame_nxt      = {{2'b00, in_f.cmd_index} | sdspi_pkg::CMD_START_BITS,
                            in_f.cmd_arg, in_f.cmd_crc | sdspi_pkg::CRC_END_BIT};
          long_reply_nxt = in_f.resp_long;
          phase_nxt      = PH_C_PRE;
        end else begin
          long_reply_nxt = 1'b0;
          phase_nxt      = PH_P_PRE;
        end
      end
    end else if (in_tuser == sdspi_pkg::CMD_RX_BYTE) begin
      res_kind    = sdspi_pkg::KIND_XMIT;
      res.tx_byte = sdspi_pkg::IDLE_BYTE;
      res.cs_active = 1'b1;
      unique case (phase_r)
        PH_P_PRE: begin
          if (sync_count_r == 8'd0) begin
            phase_nxt     = PH_P_POST;
            res.cs_active = 1'b0;
          end else begin
            byte_count_nxt = 8'd1;
            phase_nxt      = PH_P_SYNC;
          end
        end
        PH_P_SYNC: begin
          if (byte_count_r < sync_count_r) begin
            byte_count_nxt = byte_count_r + 8'd1;
          end else begin
            phase_nxt     = PH_P_POST;
            res.cs_active = 1'b0;
          end
        end
        PH_C_PRE: begin
          phase_nxt = PH_C_SEL;
        end
        PH_C_SEL: begin
          // The frame is shifted up so that the byte to send is always on top.
          byte_count_nxt = 8'd1;
          phase_nxt      = PH_C_FRAME;
          res.tx_byte    = frame_r[47:40];
          frame_nxt      = {frame_r[39:0], 8'h00};
        end
        PH_C_FRAME: begin
          if (byte_count_r < sdspi_pkg::FRAME_BYTES) begin
            byte_count_nxt = byte_count_r + 8'd1;
            res.tx_byte    = frame_r[47:40];
            frame_nxt      = {frame_r[39:0], 8'h00};
          end else begin
            poll_count_nxt = 8'd1;
            phase_nxt      = PH_C_POLL;
          end
        end
        PH_C_POLL: begin
          if (in_f.rx_byte != sdspi_pkg::IDLE_BYTE || poll_count_r >= limit) begin
            r1_hold_nxt = r1_sel;
            if (long_reply_r && r1_sel <= 8'd1) begin
              byte_count_nxt = 8'd1;
              phase_nxt      = PH_C_DATA;
            end else begin
              phase_nxt = PH_C_TAIL;
            end
          end else begin
            poll_count_nxt = poll_count_r + 8'd1;
          end
        end
        PH_C_DATA: begin
          data_hold_nxt = {data_hold_r[23:0], in_f.rx_byte};
          if (byte_count_r < sdspi_pkg::DATA_BYTES) begin
            byte_count_nxt = byte_count_r + 8'd1;
          end else begin
            phase_nxt = PH_C_TAIL;
          end
        end
        PH_C_TAIL: begin
          phase_nxt     = PH_C_END;
          res.cs_active = 1'b0;
        end
        PH_P_POST, PH_C_END: begin
          phase_nxt     = PH_IDLE;
          res_kind      = sdspi_pkg::KIND_DONE;
          res.tx_byte   = '0;
          res.cs_active = 1'b0;
          res.r1_status = r1_hold_r;
          res.resp_data = data_hold_r;
        end
        default: begin
          res_kind      = sdspi_pkg::KIND_IGNORED;
          res.tx_byte   = '0;
          res.cs_active = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      frame_r      <= '0;
      byte_count_r <= '0;
      poll_count_r <= '0;
      r1_hold_r    <= sdspi_pkg::IDLE_BYTE;
      data_hold_r  <= '0;
      long_reply_r <= 1'b0;
      poll_limit_r <= sdspi_pkg::POLL_LIMIT_RST;
      sync_count_r <= sdspi_pkg::SYNC_COUNT_RST;
      out_valid_r  <= 1'b0;
      out_kind_r   <= sdspi_pkg::KIND_IGNORED;
      out_fields_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == sdspi_pkg::CFG_POLL_LIMIT) begin
          poll_limit_r <= cfg_data;
        end else begin
          sync_count_r <= cfg_data;
        end
      end
      if (in_acc) begin
        phase_r      <= phase_nxt;
        frame_r      <= frame_nxt;
        byte_count_r <= byte_count_nxt;
        poll_count_r <= poll_count_nxt;
        r1_hold_r    <= r1_hold_nxt;
        data_hold_r  <= data_hold_nxt;
        long_reply_r <= long_reply_nxt;
        out_valid_r  <= 1'b1;
        out_kind_r   <= res_kind;
        out_fields_r <= res;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {7'd0, out_fields_r};

  // A start request during a running sequence must be turned away.
  a_busy_start_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && phase_r != PH_IDLE &&
     (in_tuser == sdspi_pkg::CMD_START_CMD || in_tuser == sdspi_pkg::CMD_START_SYNC))
    |=> (out_tuser == sdspi_pkg::KIND_IGNORED && phase_r == $past(phase_r)))
    else $error("start request accepted while a sequence was running");

  // A finished reply always leaves the sequencer idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == sdspi_pkg::KIND_DONE) |-> (phase_r == PH_IDLE))
    else $error("done reported while sequencer not idle");

  // The frame counter never runs past the six command bytes.
  a_frame_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_C_FRAME) |-> (byte_count_r >= 8'd1 && byte_count_r <= 8'd6))
    else $error("frame byte counter out of range");

  // Data bytes are only collected for a long reply with a good R1.
  a_data_long: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_C_DATA) |-> (long_reply_r && r1_hold_r <= 8'd1))
    else $error("reading reply data without a long reply");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  // The one request code that the block never decodes.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int PHASE_REQS = 130;
  localparam int STALL_LIMIT = 2000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SYNC_LEAD, ST_SYNC_SEL, ST_SYNC_TRAIL, ST_CMD_LEAD, ST_CMD_SEL,
    ST_CMD_FRAME, ST_CMD_POLL, ST_CMD_DATA, ST_CMD_TAIL, ST_CMD_END
  } seq_state_t;

  typedef struct packed {
    logic [1:0]             kind;
    sdspi_pkg::out_fields_t f;
  } reply_t;

  typedef struct {
    logic [1:0]            cmd;
    sdspi_pkg::in_fields_t req;
    bit                    typed;
    reply_t                want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = '0;

  // Shadow of the sequencer state and its two configuration registers.
  seq_state_t  st = ST_IDLE;
  logic [47:0] frame_bits = '0;
  logic [7:0]  step_cnt = '0;
  logic [7:0]  poll_cnt = '0;
  logic [7:0]  r1_seen = sdspi_pkg::IDLE_BYTE;
  logic [31:0] reply_word = '0;
  logic        wants_long = 1'b0;
  logic [7:0]  poll_limit_reg = sdspi_pkg::POLL_LIMIT_RST;
  logic [7:0]  sync_count_reg = sdspi_pkg::SYNC_COUNT_RST;

  reply_t    replies_due[$];
  stim_row_t directed_rows[$];
  bit        steady = 1'b0;
  int        mismatches = 0;
  int        items_served = 0;
  int        items_ignored = 0;
  int        replies_checked = 0;
  int        cmd_starts = 0;
  int        sync_starts = 0;
  int        settings_written = 0;

  sd_spi_command_sequencer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic reply_t mk_reply(input logic [1:0] kind, input logic [7:0] tx,
                                      input logic cs, input logic [7:0] r1,
                                      input logic [31:0] data);
    reply_t r;
    r.kind = kind;
    r.f.tx_byte = tx;
    r.f.cs_active = cs;
    r.f.r1_status = r1;
    r.f.resp_data = data;
    return r;
  endfunction

  // Steps the shadow sequencer by one request and returns the reply it should give.
  function automatic reply_t advance_sequencer(input logic [1:0] cmd,
                                               input sdspi_pkg::in_fields_t req);
    reply_t     r;
    logic [7:0] limit;
    r = mk_reply(sdspi_pkg::KIND_IGNORED, 8'h00, 1'b0, 8'h00, 32'h0);
    limit = (poll_limit_reg == 8'd0) ? 8'd1 : poll_limit_reg;
    if (cmd == sdspi_pkg::CMD_START_CMD || cmd == sdspi_pkg::CMD_START_SYNC) begin
      if (st == ST_IDLE) begin
        r1_seen = sdspi_pkg::IDLE_BYTE;
        reply_word = '0;
        step_cnt = '0;
        poll_cnt = '0;
        if (cmd == sdspi_pkg::CMD_START_CMD) begin
          frame_bits = {sdspi_pkg::CMD_START_BITS | {2'b00, req.cmd_index}, req.cmd_arg,
                        req.cmd_crc | sdspi_pkg::CRC_END_BIT};
          wants_long = req.resp_long;
          st = ST_CMD_LEAD;
          cmd_starts++;
        end else begin
          wants_long = 1'b0;
          st = ST_SYNC_LEAD;
          sync_starts++;
        end
        r = mk_reply(sdspi_pkg::KIND_XMIT, sdspi_pkg::IDLE_BYTE, 1'b0, 8'h00, 32'h0);
      end
    end else if (cmd == sdspi_pkg::CMD_RX_BYTE) begin
      case (st)
        ST_SYNC_LEAD: begin
          if (sync_count_reg == 8'd0) begin
            st = ST_SYNC_TRAIL;
            r = mk_reply(sdspi_pkg::KIND_XMIT, sdspi_pkg::IDLE_BYTE, 1'b0, 8'h00, 32'h0);
          end else begin
            step_cnt = 8'd1;
            st = ST_SYNC_SEL;
            r = mk_reply(sdspi_pkg::KIND_XMIT, sdspi_pkg::IDLE_BYTE, 1'b1, 8'h00, 32'h0);
          end
        end
        ST_SYNC_SEL: begin
          if (step_cnt < sync_count_reg) begin
            step_cnt++;
            r = mk_reply(sdspi_pkg::KIND_XMIT, sdspi_pkg::IDLE_BYTE, 1'b1, 8'h00, 32'h0);
          end else begin
            st = ST_SYNC_TRAIL;
            r = mk_reply(sdspi_pkg::KIND_XMIT, sdspi_pkg::IDLE_BYTE, 1'b0, 8'h00, 32'h0);
          end
        end
        ST_CMD_LEAD: begin
          st = ST_CMD_SEL;
          r = mk_reply(sdspi_pkg::KIND_XMIT, sdspi_pkg::IDLE_BYTE, 1'b1, 8'h00, 32'h0);
        end
        ST_CMD_SEL: begin
          step_cnt = 8'd1;
          st = ST_CMD_FRAME;
          r = mk_reply(sdspi_pkg::KIND_XMIT, frame_bits[47:40], 1'b1, 8'h00, 32'h0);
        end
        ST_CMD_FRAME: begin
          if (step_cnt < sdspi_pkg::FRAME_BYTES) begin
            r = mk_reply(sdspi_pkg::KIND_XMIT, frame_bits[8*(5-step_cnt) +: 8], 1'b1,
                         8'h00, 32'h0);
            step_cnt++;
          end else begin
            poll_cnt = 8'd1;
            st = ST_CMD_POLL;
            r = mk_reply(sdspi_pkg::KIND_XMIT, sdspi_pkg::IDLE_BYTE, 1'b1, 8'h00, 32'h0);
          end
        end
        ST_CMD_POLL: begin
          // A byte of all ones is no answer; once the poll budget is spent it stands as r1.
          if (req.rx_byte != sdspi_pkg::IDLE_BYTE || poll_cnt >= limit) begin
            r1_seen = req.rx_byte;
            if (wants_long && r1_seen <= 8'd1) begin
              step_cnt = 8'd1;
              st = ST_CMD_DATA;
            end else begin
              st = ST_CMD_TAIL;
            end
          end else begin
            poll_cnt++;
          end
          r = mk_reply(sdspi_pkg::KIND_XMIT, sdspi_pkg::IDLE_BYTE, 1'b1, 8'h00, 32'h0);
        end
        ST_CMD_DATA: begin
          reply_word = {reply_word[23:0], req.rx_byte};
          if (step_cnt < sdspi_pkg::DATA_BYTES) begin
            step_cnt++;
          end else begin
            st = ST_CMD_TAIL;
          end
          r = mk_reply(sdspi_pkg::KIND_XMIT, sdspi_pkg::IDLE_BYTE, 1'b1, 8'h00, 32'h0);
        end
        ST_CMD_TAIL: begin
          st = ST_CMD_END;
          r = mk_reply(sdspi_pkg::KIND_XMIT, sdspi_pkg::IDLE_BYTE, 1'b0, 8'h00, 32'h0);
        end
        ST_SYNC_TRAIL, ST_CMD_END: begin
          st = ST_IDLE;
          r = mk_reply(sdspi_pkg::KIND_DONE, 8'h00, 1'b0, r1_seen, reply_word);
        end
        default: begin
        end
      endcase
    end
    return r;
  endfunction

  function automatic sdspi_pkg::in_fields_t random_request();
    sdspi_pkg::in_fields_t r;
    r.cmd_index = 6'($urandom_range(63));
    r.cmd_arg = $urandom;
    r.cmd_crc = 8'($urandom_range(255));
    r.resp_long = 1'($urandom_range(1));
    r.rx_byte = 8'($urandom_range(255));
    return r;
  endfunction

  function automatic logic [1:0] stray_code();
    case ($urandom_range(2))
      0: begin
        return sdspi_pkg::CMD_START_CMD;
      end
      1: begin
        return sdspi_pkg::CMD_START_SYNC;
      end
      default: begin
        return CMD_UNUSED;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] wanted);
    mismatches++;
    $display("MISMATCH at %0t on reply %0d: %s got %0h, wanted %0h",
             $realtime, replies_checked, what, got, wanted);
  endtask

  // Offers one request, waits for it to be taken and records the reply it must produce.
  task automatic issue(input logic [1:0] cmd, input sdspi_pkg::in_fields_t req,
                       input bit typed, input reply_t typed_want);
    reply_t want;
    while (!steady && $urandom_range(99) < 16) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {1'b0, req};
    do @(posedge clk); while (!in_tready);
    want = advance_sequencer(cmd, req);
    replies_due.push_back(typed ? typed_want : want);
    if (want.kind == sdspi_pkg::KIND_IGNORED) begin
      items_ignored++;
    end else begin
      items_served++;
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] poll, input logic [7:0] sync);
    cfg_valid <= 1'b1;
    cfg_index <= sdspi_pkg::CFG_POLL_LIMIT;
    cfg_data <= poll;
    do @(posedge clk); while (!cfg_ready);
    poll_limit_reg = poll;
    cfg_index <= sdspi_pkg::CFG_SYNC_COUNT;
    cfg_data <= sync;
    do @(posedge clk); while (!cfg_ready);
    sync_count_reg = sync;
    cfg_valid <= 1'b0;
    settings_written++;
  endtask

  // A well-formed sync or command with random content; the card answers after a few polls,
  // or not at all, and now and then a stray request lands in the middle.
  task automatic run_transaction(input bit is_sync);
    sdspi_pkg::in_fields_t req;
    int                    lim;
    int                    wait_polls;
    int                    polls_seen;
    logic [7:0]            r1_pick;
    req = random_request();
    issue(is_sync ? sdspi_pkg::CMD_START_SYNC : sdspi_pkg::CMD_START_CMD, req, 1'b0, '0);
    lim = (poll_limit_reg == 8'd0) ? 1 : int'(poll_limit_reg);
    if ($urandom_range(99) < 15) begin
      wait_polls = lim;
    end else begin
      wait_polls = int'($urandom_range(0, (lim > 4) ? 4 : lim - 1));
    end
    r1_pick = ($urandom_range(99) < 60) ? 8'($urandom_range(1)) : 8'($urandom_range(254));
    polls_seen = 0;
    while (st != ST_IDLE) begin
      if ($urandom_range(99) < 4) begin
        issue(stray_code(), random_request(), 1'b0, '0);
      end
      req = random_request();
      if (st == ST_CMD_POLL) begin
        req.rx_byte = (polls_seen == wait_polls) ? r1_pick : sdspi_pkg::IDLE_BYTE;
        polls_seen++;
      end
      issue(sdspi_pkg::CMD_RX_BYTE, req, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin : check_replies
    reply_t                 due;
    sdspi_pkg::out_fields_t seen;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      seen = out_tdata[48:0];
      if (replies_due.size() == 0) begin
        report_mismatch("reply with no request pending, kind", 32'(out_tuser), 32'h0);
      end else begin
        due = replies_due.pop_front();
        if (out_tuser !== due.kind)
          report_mismatch("result kind", 32'(out_tuser), 32'(due.kind));
        if (seen.tx_byte !== due.f.tx_byte)
          report_mismatch("tx byte", 32'(seen.tx_byte), 32'(due.f.tx_byte));
        if (seen.cs_active !== due.f.cs_active)
          report_mismatch("chip select", 32'(seen.cs_active), 32'(due.f.cs_active));
        if (seen.r1_status !== due.f.r1_status)
          report_mismatch("r1 status", 32'(seen.r1_status), 32'(due.f.r1_status));
        if (seen.resp_data !== due.f.resp_data)
          report_mismatch("response data", seen.resp_data, due.f.resp_data);
        replies_checked++;
      end
    end
    out_tready <= steady || ($urandom_range(99) >= 16);
  end

  initial begin : stall_watch
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid === 1'b1 && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        stalled = 0;
      end else begin
        stalled++;
      end
    end
    $display("Timed out after %0d cycles without a transfer", STALL_LIMIT);
    $display("sd_spi_command_sequencer verification failed");
    $finish;
  end

  initial begin : stimulus
    sdspi_pkg::in_fields_t row_req;
    logic [7:0]            poll_plan [7];
    logic [7:0]            sync_plan [7];
    int                    mark;
    int                    pick;
    poll_plan = '{8'd9, 8'd1, 8'd0, 8'd255, 8'd2, 8'd0, 8'd9};
    sync_plan = '{8'd74, 8'd1, 8'd0, 8'd255, 8'd3, 8'd0, 8'd74};
    poll_plan[5] = 8'($urandom_range(255));
    sync_plan[5] = 8'($urandom_range(255));
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Stray requests while idle, then a long-reply command with extreme fields that the
    // card never answers, so polling runs out at the reset limit. A sync request lands
    // while it is busy.
    row_req = '0;
    row_req.rx_byte = 8'hA5;
    directed_rows.push_back('{sdspi_pkg::CMD_RX_BYTE, row_req, 1'b1,
                              mk_reply(sdspi_pkg::KIND_IGNORED, 8'h00, 1'b0, 8'h00, 32'h0)});
    directed_rows.push_back('{CMD_UNUSED, '1, 1'b1,
                              mk_reply(sdspi_pkg::KIND_IGNORED, 8'h00, 1'b0, 8'h00, 32'h0)});
    row_req = '{rx_byte: 8'h00, resp_long: 1'b1, cmd_crc: 8'hFE, cmd_arg: 32'hFFFF_FFFF,
                cmd_index: 6'd63};
    directed_rows.push_back('{sdspi_pkg::CMD_START_CMD, row_req, 1'b1,
                              mk_reply(sdspi_pkg::KIND_XMIT, sdspi_pkg::IDLE_BYTE, 1'b0,
                                       8'h00, 32'h0)});
    directed_rows.push_back('{sdspi_pkg::CMD_START_SYNC, '0, 1'b1,
                              mk_reply(sdspi_pkg::KIND_IGNORED, 8'h00, 1'b0, 8'h00, 32'h0)});
    for (int i = 0; i < 18; i++) begin
      row_req = '0;
      row_req.rx_byte = (i < 8 && i % 2 == 0) ? 8'h00 : sdspi_pkg::IDLE_BYTE;
      directed_rows.push_back('{sdspi_pkg::CMD_RX_BYTE, row_req, 1'b0, '0});
    end
    row_req = '0;
    directed_rows.push_back('{sdspi_pkg::CMD_RX_BYTE, row_req, 1'b1,
                              mk_reply(sdspi_pkg::KIND_DONE, 8'h00, 1'b0,
                                       sdspi_pkg::IDLE_BYTE, 32'h0)});
    foreach (directed_rows[i]) begin
      issue(directed_rows[i].cmd, directed_rows[i].req, directed_rows[i].typed,
            directed_rows[i].want);
    end
    settle();

    for (int p = 0; p < 7; p++) begin
      if (p > 0) begin
        write_regs(poll_plan[p], sync_plan[p]);
      end
      steady = (p == 4);
      mark = items_served;
      while (items_served - mark < PHASE_REQS) begin
        pick = int'($urandom_range(99));
        if (pick < 8) begin
          issue(($urandom_range(1) == 0) ? sdspi_pkg::CMD_RX_BYTE : CMD_UNUSED,
                random_request(), 1'b0, '0);
        end else begin
          run_transaction(pick < 22);
        end
      end
      settle();
    end
    steady = 1'b0;
    repeat (4) @(posedge clk);

    $display("Run covered %0d requests served and %0d ignored, %0d replies checked.",
             items_served, items_ignored, replies_checked);
    $display("%0d commands and %0d power-up syncs started over %0d register settings.",
             cmd_starts, sync_starts, settings_written + 1);
    if (mismatches == 0) begin
      $display("sd_spi_command_sequencer verification clean");
    end else begin
      $display("sd_spi_command_sequencer verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sdspi_pkg.sv
rtl/sd_spi_command_sequencer.sv
tb/sv/testbench.sv
